/* hw/rtl/pet_pkg.sv */
// Shared types and constants for the periodic event timer with catch-up.
package pet_pkg;

    localparam int TIME_W       = 48;
    localparam int PERIOD_W     = 32;
    localparam int CAP_W        = 16;
    localparam int TAGCNT_W     = 31;
    localparam int POST_W       = 6;
    localparam int CLASS_W      = 2;
    localparam int SLEEP_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int DIV_CNT_W    = 6;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_CATCH_UP = 40;
    localparam int MIN_SLEEP_MS = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 32'd1000;
    localparam logic [CAP_W-1:0]    CAPACITY_RESET = 16'd6;
    localparam logic [CAP_W-1:0]    CAPACITY_MAX   = 16'hffff;
    localparam logic [30:0]         DIST_CLIP      = 31'h7fffffff;
    localparam logic [30:0]         FRAC_MASK      = 31'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [SLEEP_W:0]    SLEEP_MAX      = 17'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD       = 3'd0,
        CFG_TIMER_ON     = 3'd1,
        CFG_QUEUE_CAP    = 3'd2,
        CFG_SINGLE_LIMIT = 3'd3,
        CFG_DISPATCH     = 3'd4
    } cfg_index_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NORMAL    = 2'd0,
        CLS_EXCLUSIVE = 2'd1,
        CLS_IDLE      = 2'd2,
        CLS_UNUSED    = 2'd3
    } event_class_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FIN
    } pet_state_t;

    typedef struct packed {
        logic start;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [TIME_W-1:0]   quotient;
        logic [PERIOD_W-1:0] remainder;
    } div_rsp_t;

endpackage

/* hw/rtl/pet_divider.sv */
// Restoring divider, one quotient bit per cycle, for elapsed time over period.
module pet_divider
    import pet_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0]    qd_reg, qd_next;
    logic [PERIOD_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PERIOD_W:0]    trial;
    logic [PERIOD_W+1:0]  diff;

    assign trial = {rem_reg, qd_reg[TIME_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            qd_next   = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = diff[PERIOD_W+1] ? trial[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
            qd_next  = {qd_reg[TIME_W-2:0], ~diff[PERIOD_W+1]};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = qd_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* hw/rtl/periodic_event_timer_catch_up.sv */
// Periodic event timer with missed-period catch-up: sequencer, config and result register.
// Sequence: capture the input, evaluate, then for a due pass run the 48-step divide of elapsed
// time (one bit per cycle) and register the result; restart, idle and not-due passes skip the divide.
// Throughput: one transaction in flight; next input taken once the result is registered.
// Reset: config registers take their defaults, next due time and tag counter clear,
// no result pending. No clearing pass.
module periodic_event_timer_catch_up
    import pet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TIME_W-1:0]    now_time,
    input  logic                 restart,
    input  logic [CAP_W-1:0]     queued_events,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POST_W-1:0]    post_count,
    output logic [PERIOD_W-1:0]  event_tag,
    output logic [CLASS_W-1:0]   event_class,
    output logic [SLEEP_W-1:0]   sleep_ms,
    output logic                 sleep_forever
);

    pet_state_t state_reg, state_next;

    logic [PERIOD_W-1:0] period_reg;
    logic                timer_on_reg;
    logic [CAP_W-1:0]    capacity_reg;
    logic                single_reg;
    logic [CLASS_W-1:0]  dispatch_reg;

    logic [TIME_W-1:0]   next_due_reg, next_due_next;
    logic [TAGCNT_W-1:0] counter_reg, counter_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                restart_reg, restart_next;
    logic [CAP_W-1:0]    queued_reg, queued_next;
    logic [POST_W-1:0]   fire_reg, fire_next;

    logic                out_valid_reg, out_valid_next;
    logic [POST_W-1:0]   post_reg, post_next;
    logic [PERIOD_W-1:0] tag_reg, tag_next;
    logic [CLASS_W-1:0]  class_reg, class_next;
    logic [SLEEP_W-1:0]  sleep_reg, sleep_next;
    logic                forever_reg, forever_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                active;
    logic                catch_up_sat;
    logic [CAP_W-1:0]    cap;
    logic [CAP_W-1:0]    room;
    logic [TIME_W-1:0]   due_gap;
    logic [30:0]         due_gap_c;
    logic [SLEEP_W:0]    sleep_sum;
    logic [SLEEP_W:0]    sleep_sat;

    pet_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RESET;
            timer_on_reg <= 1'b0;
            capacity_reg <= CAPACITY_RESET;
            single_reg   <= 1'b0;
            dispatch_reg <= CLS_NORMAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD:       period_reg   <= cfg_wdata;
                CFG_TIMER_ON:     timer_on_reg <= cfg_wdata[0];
                CFG_QUEUE_CAP:    capacity_reg <= cfg_wdata[CAP_W-1:0];
                CFG_SINGLE_LIMIT: single_reg   <= cfg_wdata[0];
                CFG_DISPATCH:     dispatch_reg <= cfg_wdata[CLASS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign active       = timer_on_reg && (period_reg != '0);
    assign catch_up_sat = div_rsp.quotient >= TIME_W'(MAX_CATCH_UP);
    assign cap          = single_reg ? CAP_W'(1)
                        : ((capacity_reg == '0) ? CAPACITY_MAX : capacity_reg);
    assign room         = cap - queued_reg;
    assign due_gap      = next_due_reg - now_reg;
    assign due_gap_c    = (|due_gap[TIME_W-1:31]) ? DIST_CLIP : due_gap[30:0];
    assign sleep_sum    = (SLEEP_W+1)'(due_gap_c >> FRAC_BITS)
                        + (SLEEP_W+1)'(|(due_gap_c & FRAC_MASK));
    assign sleep_sat    = (sleep_sum < (SLEEP_W+1)'(MIN_SLEEP_MS)) ? (SLEEP_W+1)'(MIN_SLEEP_MS)
                        : ((sleep_sum > SLEEP_MAX) ? SLEEP_MAX : sleep_sum);

    always_comb
    begin
        state_next       = state_reg;
        next_due_next    = next_due_reg;
        counter_next     = counter_reg;
        now_next         = now_reg;
        restart_next     = restart_reg;
        queued_next      = queued_reg;
        fire_next        = fire_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        post_next        = post_reg;
        tag_next         = tag_reg;
        class_next       = class_reg;
        sleep_next       = sleep_reg;
        forever_next     = forever_reg;
        in_ready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = now_reg - next_due_reg;
        div_req.divisor  = period_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    now_next     = now_time;
                    restart_next = restart;
                    queued_next  = queued_events;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                fire_next = '0;
                if (restart_reg)
                begin
                    next_due_next = now_reg + TIME_W'(period_reg);
                    state_next    = S_FIN;
                end
                else if (active && (next_due_reg < now_reg))
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (catch_up_sat)
                    begin
                        fire_next     = POST_W'(1);
                        next_due_next = now_reg + TIME_W'(period_reg);
                    end
                    else
                    begin
                        // elapsed = missed * period + rem, so the new due time is now - rem + period
                        fire_next     = div_rsp.quotient[POST_W-1:0] + POST_W'(1);
                        next_due_next = now_reg - TIME_W'(div_rsp.remainder)
                                      + TIME_W'(period_reg);
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    post_next      = '0;
                    tag_next       = '0;
                    class_next     = CLS_NORMAL;
                    if ((fire_reg != '0) && (cap > queued_reg))
                    begin
                        post_next    = ((CAP_W'(fire_reg)) < room) ? fire_reg : room[POST_W-1:0];
                        tag_next     = {counter_reg, 1'b1};
                        class_next   = (dispatch_reg == CLS_UNUSED) ? CLS_NORMAL : dispatch_reg;
                        counter_next = counter_reg + TAGCNT_W'(1);
                    end
                    if (active)
                    begin
                        sleep_next   = sleep_sat[SLEEP_W-1:0];
                        forever_next = 1'b0;
                    end
                    else
                    begin
                        sleep_next   = '0;
                        forever_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_due_reg  <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_due_reg  <= next_due_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        restart_reg <= restart_next;
        queued_reg  <= queued_next;
        fire_reg    <= fire_next;
        post_reg    <= post_next;
        tag_reg     <= tag_next;
        class_reg   <= class_next;
        sleep_reg   <= sleep_next;
        forever_reg <= forever_next;
    end

    assign out_valid     = out_valid_reg;
    assign post_count    = post_reg;
    assign event_tag     = tag_reg;
    assign event_class   = class_reg;
    assign sleep_ms      = sleep_reg;
    assign sleep_forever = forever_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EVAL))
        else $error("input transaction did not start evaluation");

    a_post_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (post_count <= POST_W'(MAX_CATCH_UP)))
        else $error("post count above catch-up limit");

    a_no_post_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (post_count == '0)) |-> ((event_tag == '0) && (event_class == CLS_NORMAL)))
        else $error("tag or class set without posts");

    a_forever_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sleep_forever ? (sleep_ms == '0)
                                     : (sleep_ms >= SLEEP_W'(MIN_SLEEP_MS))))
        else $error("sleep time inconsistent with forever flag");

endmodule

/* tb/sv/periodic_event_timer_catch_up_tb.sv */
// Self-checking testbench for the periodic event timer: directed table, then random passes.
module periodic_event_timer_catch_up_tb
    import pet_pkg::*;
();

    typedef struct packed {
        logic [POST_W-1:0]   posts;
        logic [PERIOD_W-1:0] tag;
        event_class_t        cls;
        logic [SLEEP_W-1:0]  sleep;
        logic                no_due;
    } pass_result_t;

    typedef enum logic {STEP_PASS, STEP_CFG} step_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        cfg_index_t        idx;
        logic [TIME_W-1:0] t;
        logic              rs;
        logic [CAP_W-1:0]  q;
        logic              fixed;
        pass_result_t      want;
    } dir_row_t;

    localparam pass_result_t OFF_RES = '{6'd0, 32'd0, CLS_NORMAL, 16'd0, 1'b1};
    localparam pass_result_t NOT_DUE = '{6'd0, 32'd0, CLS_NORMAL, 16'(MIN_SLEEP_MS), 1'b0};
    localparam pass_result_t ANY_RES = '{6'd0, 32'd0, CLS_NORMAL, 16'd0, 1'b0};
    localparam int N_DIR = 37;

    // value of a register write travels in the time field
    localparam dir_row_t DIRECTED_ROWS [N_DIR] = '{
        '{STEP_PASS, CFG_PERIOD, 48'd0, 1'b0, 16'd0, 1'b1, OFF_RES},
        '{STEP_PASS, CFG_PERIOD, 48'hffff_ffff_ffff, 1'b0, 16'hffff, 1'b1, OFF_RES},
        '{STEP_CFG, CFG_TIMER_ON, 48'd1, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'h1_0000, 1'b0, 16'd0, 1'b1,
          '{6'd1, 32'd1, CLS_NORMAL, 16'(MIN_SLEEP_MS), 1'b0}},
        '{STEP_PASS, CFG_PERIOD, 48'h2_0000, 1'b1, 16'd0, 1'b1, NOT_DUE},
        '{STEP_PASS, CFG_PERIOD, 48'd136572, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd140072, 1'b0, 16'd6, 1'b1, NOT_DUE},
        '{STEP_PASS, CFG_PERIOD, 48'd143572, 1'b0, 16'd4, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd144072, 1'b0, 16'd0, 1'b1, NOT_DUE},
        '{STEP_CFG, CFG_DISPATCH, 48'(CLS_EXCLUSIVE), 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_CFG, CFG_QUEUE_CAP, 48'd0, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd146000, 1'b0, 16'hffff, 1'b1, NOT_DUE},
        '{STEP_PASS, CFG_PERIOD, 48'd147500, 1'b0, 16'hfffe, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd1048576, 1'b1, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd1088577, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd1129577, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_CFG, CFG_SINGLE_LIMIT, 48'd1, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_CFG, CFG_DISPATCH, 48'(CLS_UNUSED), 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd1132000, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd1134000, 1'b0, 16'd1, 1'b0, ANY_RES},
        '{STEP_CFG, CFG_DISPATCH, 48'(CLS_IDLE), 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_CFG, CFG_SINGLE_LIMIT, 48'd0, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd1137000, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_CFG, CFG_PERIOD, 48'd0, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd1140000, 1'b0, 16'd0, 1'b1, OFF_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd1141000, 1'b1, 16'd0, 1'b1, OFF_RES},
        '{STEP_CFG, CFG_PERIOD, 48'hffff_ffff, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd0, 1'b1, 16'd0, 1'b1,
          '{6'd0, 32'd0, CLS_NORMAL, 16'd32768, 1'b0}},
        '{STEP_PASS, CFG_PERIOD, 48'h1_0000_0000, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_CFG, CFG_PERIOD, 48'd1000, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'hffff_ffff_fe0c, 1'b1, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'hffff_ffff_ff9c, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd0, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_CFG, CFG_TIMER_ON, 48'd0, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd5000, 1'b1, 16'd0, 1'b1, OFF_RES},
        '{STEP_CFG, CFG_TIMER_ON, 48'd1, 1'b0, 16'd0, 1'b0, ANY_RES},
        '{STEP_PASS, CFG_PERIOD, 48'd5500, 1'b0, 16'd0, 1'b0, ANY_RES}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PERIOD_W-1:0]  cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [TIME_W-1:0]    now_time;
    logic                 restart;
    logic [CAP_W-1:0]     queued_events;
    logic                 out_valid;
    logic                 out_ready;
    logic [POST_W-1:0]    post_count;
    logic [PERIOD_W-1:0]  event_tag;
    logic [CLASS_W-1:0]   event_class;
    logic [SLEEP_W-1:0]   sleep_ms;
    logic                 sleep_forever;

    // shadow of the block's registers and state
    logic [PERIOD_W-1:0]  cfg_period;
    logic                 cfg_on;
    logic [CAP_W-1:0]     cfg_cap;
    logic                 cfg_single;
    event_class_t         cfg_mode;
    logic [TIME_W-1:0]    due_time;
    logic [TAGCNT_W-1:0]  tag_count;

    pass_result_t pending_pass_results[$];
    int unsigned  n_sent;
    int unsigned  n_checked;
    int unsigned  n_errors;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    periodic_event_timer_catch_up i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_time      (now_time),
        .restart       (restart),
        .queued_events (queued_events),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .post_count    (post_count),
        .event_tag     (event_tag),
        .event_class   (event_class),
        .sleep_ms      (sleep_ms),
        .sleep_forever (sleep_forever)
    );

    always #1 clk = ~clk;

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pass_result_t want;
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pass_results.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, got post_count %0d sleep_ms %0d",
                         $time, post_count, sleep_ms);
                n_errors++;
            end
            else
            begin
                want = pending_pass_results.pop_front();
                check_field("post_count", 32'(want.posts), 32'(post_count));
                check_field("event_tag", want.tag, event_tag);
                check_field("event_class", 32'(want.cls), 32'(event_class));
                check_field("sleep_ms", 32'(want.sleep), 32'(sleep_ms));
                check_field("sleep_forever", 32'(want.no_due), 32'(sleep_forever));
                n_checked++;
            end
        end
    end

    function automatic logic [CAP_W-1:0] room_limit();
        return cfg_single ? CAP_W'(1) : (cfg_cap == '0 ? CAPACITY_MAX : cfg_cap);
    endfunction

    function automatic pass_result_t predict_timer_pass(input logic [TIME_W-1:0] t,
                                                        input logic rs,
                                                        input logic [CAP_W-1:0] q);
        pass_result_t      r;
        logic              active;
        logic [63:0]       missed;
        logic [63:0]       fire_n;
        logic [63:0]       room;
        logic [CAP_W-1:0]  cap;
        logic [TIME_W-1:0] gap_to_due;
        logic [TIME_W-1:0] slp;
        r = OFF_RES;
        active = cfg_on && (cfg_period != '0);
        fire_n = '0;
        if (rs)
            due_time = t + TIME_W'(cfg_period);
        else if (active && due_time < t)
        begin
            missed = 64'(t - due_time) / 64'(cfg_period);
            if (missed >= 64'(MAX_CATCH_UP))
            begin
                fire_n = 64'd1;
                due_time = t + TIME_W'(cfg_period);
            end
            else
            begin
                fire_n = missed + 64'd1;
                due_time = due_time + TIME_W'(fire_n * 64'(cfg_period));
            end
        end
        cap = room_limit();
        if (fire_n != '0 && cap > q)
        begin
            room = 64'(cap - q);
            r.posts = POST_W'(fire_n < room ? fire_n : room);
            r.tag = {tag_count, 1'b1};
            r.cls = (cfg_mode == CLS_UNUSED) ? CLS_NORMAL : cfg_mode;
            tag_count = tag_count + TAGCNT_W'(1);
        end
        if (active)
        begin
            gap_to_due = due_time - t;
            if (gap_to_due >= TIME_W'(32'h8000_0000))
                gap_to_due = TIME_W'(DIST_CLIP);
            slp = (gap_to_due >> FRAC_BITS) + TIME_W'(gap_to_due[FRAC_BITS-1:0] != '0);
            if (slp < TIME_W'(MIN_SLEEP_MS))
                slp = TIME_W'(MIN_SLEEP_MS);
            if (slp > TIME_W'(65535))
                slp = TIME_W'(65535);
            r.sleep = SLEEP_W'(slp);
            r.no_due = 1'b0;
        end
        return r;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [PERIOD_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PERIOD:       cfg_period = v;
            CFG_TIMER_ON:     cfg_on = v[0];
            CFG_QUEUE_CAP:    cfg_cap = v[CAP_W-1:0];
            CFG_SINGLE_LIMIT: cfg_single = v[0];
            CFG_DISPATCH:     cfg_mode = event_class_t'(v[CLASS_W-1:0]);
            default:          ;
        endcase
    endtask

    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (n_checked != n_sent)
            @(posedge clk);
    endtask

    task automatic send_pass(input logic [TIME_W-1:0] t, input logic rs,
                             input logic [CAP_W-1:0] q, input logic fixed,
                             input pass_result_t want);
        int unsigned  gap;
        pass_result_t got_pred;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        now_time <= t;
        restart <= rs;
        queued_events <= q;
        do
            @(posedge clk);
        while (!in_ready);
        got_pred = predict_timer_pass(t, rs, q);
        pending_pass_results.insert(pending_pass_results.size(), fixed ? want : got_pred);
        n_sent++;
    endtask

    initial
    begin
        dir_row_t          row;
        logic [TIME_W-1:0] cur_time;
        logic [63:0]       span;
        logic [CAP_W-1:0]  cap;
        logic [CAP_W-1:0]  q;
        logic              rs;
        int unsigned       sel;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PERIOD;
        cfg_wdata = '0;
        in_valid = 1'b0;
        now_time = '0;
        restart = 1'b0;
        queued_events = '0;
        out_ready = 1'b0;
        cfg_period = PERIOD_RESET;
        cfg_on = 1'b0;
        cfg_cap = CAPACITY_RESET;
        cfg_single = 1'b0;
        cfg_mode = CLS_NORMAL;
        due_time = '0;
        tag_count = '0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_time = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == STEP_CFG)
            begin
                wait_drained();
                write_reg(row.idx, PERIOD_W'(row.t));
            end
            else
                send_pass(row.t, row.rs, row.q, row.fixed, row.want);
        end

        for (int blk = 0; blk < 16; blk++)
        begin
            // sender holds off until every transaction has come back
            wait_drained();
            case (blk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase

            sel = $urandom_range(9);
            case (sel)
                0:       write_reg(CFG_PERIOD, '0);
                1:       write_reg(CFG_PERIOD, 32'd1);
                2:       write_reg(CFG_PERIOD, 32'hffff_ffff);
                3, 4:    write_reg(CFG_PERIOD, $urandom_range(100, 5000));
                5, 6:    write_reg(CFG_PERIOD, $urandom_range(5000, 32'h10_0000));
                7:       write_reg(CFG_PERIOD, $urandom);
                default: write_reg(CFG_PERIOD, $urandom_range(32'h1_0000, 32'h40_0000));
            endcase
            write_reg(CFG_TIMER_ON, PERIOD_W'($urandom_range(9) != 0));
            sel = $urandom_range(9);
            case (sel)
                0:       write_reg(CFG_QUEUE_CAP, '0);
                1:       write_reg(CFG_QUEUE_CAP, 32'd1);
                2:       write_reg(CFG_QUEUE_CAP, 32'hffff);
                3:       write_reg(CFG_QUEUE_CAP, PERIOD_W'($urandom & 32'hffff));
                default: write_reg(CFG_QUEUE_CAP, $urandom_range(2, 12));
            endcase
            write_reg(CFG_SINGLE_LIMIT, PERIOD_W'($urandom_range(4) == 0));
            write_reg(CFG_DISPATCH, $urandom_range(3));

            span = (cfg_period == '0 || cfg_period > 32'h0400_0000) ?
                   64'h0400_0000 : 64'(cfg_period);
            cap = room_limit();

            for (int k = 0; k < 25; k++)
            begin
                sel = $urandom_range(99);
                rs = (k == 0) ? ($urandom_range(4) != 0) : (sel < 6);
                if (sel >= 6 && sel < 12)
                    cur_time = TIME_W'({$urandom, $urandom});
                else if (sel >= 12 && sel < 16)
                    cur_time = cur_time - TIME_W'($urandom_range(0, 32'(span)));
                else if (sel >= 16 && sel < 32)
                    cur_time = cur_time +
                               TIME_W'(span * $urandom_range(1, 50) + $urandom_range(0, 1));
                else
                    cur_time = cur_time + TIME_W'($urandom_range(0, 32'(3 * span)));

                sel = $urandom_range(99);
                if (sel < 60)
                    q = CAP_W'($urandom_range(0, 8));
                else if (sel < 75)
                    q = CAP_W'($urandom);
                else if (sel < 80)
                    q = cap - CAP_W'(1);
                else if (sel < 85)
                    q = cap;
                else if (sel < 90)
                    q = cap + CAP_W'(1);
                else
                    q = '0;

                send_pass(cur_time, rs, q, 1'b0, ANY_RES);
            end
        end

        wait_drained();
        repeat (64) @(posedge clk);
        if (pending_pass_results.size() != 0)
        begin
            $display("%0t: missing transactions: expected %0d more, got none", $time,
                     pending_pass_results.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("** periodic_event_timer_catch_up: PASSED **");
        else
            $display("** periodic_event_timer_catch_up: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** periodic_event_timer_catch_up: FAILED **");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/pet_pkg.sv
hw/rtl/pet_divider.sv
hw/rtl/periodic_event_timer_catch_up.sv
tb/sv/periodic_event_timer_catch_up_tb.sv
